/* rtl/scam_pkg.sv */
package scam_pkg;

   localparam int unsigned DataWidth = 32;

   // Commands from the control sequencer to each sorting lane.
   typedef struct packed {
      logic insert;  // place the offered value into its sorted position
      logic rotate;  // move every cell one step toward the head, head wraps to the tail
   } lane_ctrl_type;

endpackage

/* rtl/sort_and_compare_arrays.sv */
// Takes pairs of signed 32-bit elements, one for array A and one for array B,
// one transfer per cycle while loading, and keeps each array sorted as it
// arrives in its own lane of insertion cells, so no sort pass is needed at
// the end. Up to MAX_ELEMENTS pairs are kept; further pairs are dropped and
// reported through the overflowed flag. After the pair marked tlast, both
// lanes rotate once through all MAX_ELEMENTS cells while the heads are
// compared, then the n stored positions are sent out one per cycle as the
// output register frees up. Input is refused from the last pair until the
// final result has entered the output register.
module sort_and_compare_arrays #(
   parameter int unsigned MAX_ELEMENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value_a [31:0], value_b [63:32]
   input  logic        req_tlast,   // last_pair
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // sorted_a [31:0], sorted_b [63:32]
   output logic [1:0]  rsp_tuser,   // arrays_match [0], overflowed [1]
   output logic        rsp_tlast    // last_out
);

   localparam int unsigned CntWidth = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned DW       = scam_pkg::DataWidth;

   typedef enum logic [1:0] {
      LOAD,
      COMPARE,
      EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [CntWidth-1:0]  pos_ff, pos_in;
   logic                 ovf_ff, ovf_in;
   logic                 match_ff, match_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_a_ff, rsp_b_ff;
   logic                 rsp_match_ff, rsp_ovf_ff, rsp_last_ff;

   scam_pkg::lane_ctrl_type lane_ctrl;
   logic signed [DW-1:0]    head_a, head_b;
   logic                    in_fire, emit_fire, room, final_pos;

   assign req_tready = (state_ff == LOAD);
   assign in_fire    = req_tvalid && req_tready;
   assign room       = (cnt_ff < CntWidth'(MAX_ELEMENTS));
   assign emit_fire  = (state_ff == EMIT) && (!rsp_valid_ff || rsp_tready);
   assign final_pos  = (pos_ff == cnt_ff - CntWidth'(1));

   assign lane_ctrl.insert = in_fire && room;
   assign lane_ctrl.rotate = (state_ff == COMPARE) || emit_fire;

   scam_lane #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_lane_a (
      .clock (clock),
      .ctrl  (lane_ctrl),
      .count (cnt_ff),
      .value (req_tdata[DW-1:0]),
      .head  (head_a)
   );

   scam_lane #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_lane_b (
      .clock (clock),
      .ctrl  (lane_ctrl),
      .count (cnt_ff),
      .value (req_tdata[2*DW-1:DW]),
      .head  (head_b)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      match_in     = match_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         LOAD: begin
            if (in_fire) begin
               if (room) begin
                  cnt_in = cnt_ff + CntWidth'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = COMPARE;
                  pos_in   = '0;
                  match_in = 1'b1;
               end
            end
         end
         COMPARE: begin
            // Only the stored positions count; the rotation still runs over
            // every cell so that the lanes end up in their original order.
            if ((pos_ff < cnt_ff) && (head_a != head_b)) begin
               match_in = 1'b0;
            end
            pos_in = pos_ff + CntWidth'(1);
            if (pos_ff == CntWidth'(MAX_ELEMENTS - 1)) begin
               state_in = EMIT;
               pos_in   = '0;
            end
         end
         EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               pos_in       = pos_ff + CntWidth'(1);
               if (final_pos) begin
                  state_in = LOAD;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         match_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_a_ff     <= head_a;
         rsp_b_ff     <= head_b;
         rsp_match_ff <= match_ff;
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= final_pos;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_b_ff, rsp_a_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_match_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/scam_lane.sv */
module scam_lane #(
   parameter int unsigned MAX_ELEMENTS = 16
) (
   input  logic                                    clock,
   input  scam_pkg::lane_ctrl_type                 ctrl,
   input  logic [$clog2(MAX_ELEMENTS + 1) - 1 : 0] count,
   input  logic signed [scam_pkg::DataWidth - 1:0] value,
   output logic signed [scam_pkg::DataWidth - 1:0] head
);

   localparam int unsigned CntWidth = $clog2(MAX_ELEMENTS + 1);

   logic signed [scam_pkg::DataWidth - 1:0] cell_ff [MAX_ELEMENTS];
   logic signed [scam_pkg::DataWidth - 1:0] cell_in [MAX_ELEMENTS];
   logic [MAX_ELEMENTS - 1:0] greater;

   // Cells 0..count-1 hold the values seen so far in ascending order. A new
   // value lands in front of the first cell that is larger; those behind move
   // up by one.
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic occupied;
      logic take;
      logic signed [scam_pkg::DataWidth - 1:0] shift_src;

      assign occupied  = (CntWidth'(i) < count);
      assign greater[i] = occupied && (cell_ff[i] > value);
      assign take      = greater[i] || (CntWidth'(i) == count);

      if (i == 0) begin : g_first
         assign shift_src = value;
      end else begin : g_rest
         assign shift_src = greater[i - 1] ? cell_ff[i - 1] : value;
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (ctrl.rotate) begin
            cell_in[i] = cell_ff[(i + 1) % MAX_ELEMENTS];
         end else if (ctrl.insert && take) begin
            cell_in[i] = shift_src;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   assign head = cell_ff[0];

endmodule

/* rtl/scam_checker.sv */
module scam_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tlast
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // The final pair of a run starts the sort and compare, so input closes.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still open after the final pair");

   // While loading, only the final result of the previous run may be pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && req_tready |-> rsp_tlast)
      else $error("input open while a run is still being sent");

   // Reset leaves no result pending.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result pending right after reset");

endmodule

bind sort_and_compare_arrays scam_checker u_scam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);
